// ===== rtl/shg_pkg.sv =====
// Package for the horizontal 3x3 Sobel gradient block.
// Holds field widths, register reset values, buffer depth, register and op codes, result and control types.
// No dependencies.
package shg_pkg;

   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int PIX_W           = 8;
   localparam int FRAME_WIDTH_W   = 11;
   localparam int FRAME_HEIGHT_W  = 13;
   localparam int FRAME_WIDTH_RST = 640;
   localparam int FRAME_HEIGHT_RST = 480;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = FRAME_HEIGHT_W;

   // result buffer depth; four entries cover the pipeline at full rate
   localparam int OUT_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 4'd0,
      CSR_FRAME_HEIGHT = 4'd1
   } shg_csr_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } shg_op_type;

   typedef struct packed {
      logic             frame_end;
      logic [PIX_W-1:0] pixel;
   } shg_rsp_type;

   // control carried with an item from the memory read to the compute stage
   typedef struct packed {
      logic is_pixel;   // pixel item: writes the line memory, shifts the window
      logic emit;       // produces a result
      logic interior;   // result is a Sobel sum, not a copied border pixel
      logic last;       // result closes the frame
      logic sel_newer;  // drain result comes from the newer line
   } shg_ctl_type;

endpackage

// ===== rtl/sobel_horizontal_gradient_3x3.sv =====
// Horizontal 3x3 Sobel gradient over an 8-bit raster stream.
// Usage:
//   req_ channel carries one beat per pixel (req_op = pixel) or flush step.
//   rsp_ channel returns one result beat per emitted pixel; rsp_frame_end
//   marks the last result of a frame. csr_ channel writes frame_width
//   (index 0) and frame_height (index 1); a write to either restarts the frame.
//   The result for raster position q is caused by pixel q+W+1; after the
//   frame's last pixel, W+1 flush beats drain the rest (a pixel beat sent
//   then is dropped and acts as a flush).
//   Each result goes through the compute-stage register, then the buffer.
//   Throughput: one beat per cycle while req_ready is high, bounded by the
//   single read-modify-write of the line memory per pixel; a same-entry
//   access back to back is forwarded from the write stage.
//   Reset: positions and window clear, width/height return to 640/480; the
//   line memory is not cleared and needs no clearing pass.
//   Stall: up to four results are buffered; req_ready drops when the buffer
//   plus the compute stage are full, and recovers in the cycle after a result is taken.
//   csr_ready is always high; write only while the block is idle.
module sobel_horizontal_gradient_3x3 import shg_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic [PIX_W-1:0]          req_pixel_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PIX_W-1:0]          rsp_pixel_out,
   output logic                      rsp_frame_end,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = FRAME_HEIGHT_W;
   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int MEM_W = 2 * PIX_W;
   localparam int SUM_W = PIX_W + 3;
   localparam int WLAST_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH - 1
                                                            : FRAME_WIDTH_RST - 1;

   // configuration, kept as last column / last row
   logic [COL_W-1:0] wlast_ff, wlast_in;
   logic [ROW_W-1:0] hlast_ff, hlast_in;
   logic             cfg_hit;

   // positions
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   // accept stage
   logic             req_accept, drain, pix_emit, launch;
   logic             out_row_last, out_col_last, frame_last;
   logic [COL_W-1:0] rd_addr;

   // compute stage
   logic             p1_valid_ff, p1_valid_in;
   shg_ctl_type      p1_ctl_ff, p1_ctl_in;
   logic [COL_W-1:0] p1_addr_ff;
   logic [PIX_W-1:0] p1_pix_ff;
   logic             fwd_ff, fwd_in;
   logic [MEM_W-1:0] fwd_data_ff;

   // line memory: [15:8] older row, [7:0] newer row
   logic [MEM_W-1:0] line_mem_ff [MAX_WIDTH];
   logic [MEM_W-1:0] rd_data_ff;
   logic [MEM_W-1:0] wr_data;
   logic             mem_we;

   logic [PIX_W-1:0] top, mid;
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];
   logic [SUM_W-1:0] d_top, d_mid, d_bot, sum, sum_abs;
   logic [PIX_W-1:0] res_pixel;
   logic             push, pop;

   // result buffer
   shg_rsp_type      fifo_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      cfg_hit  = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               cfg_hit = 1'b1;
               if (csr_wdata[FRAME_WIDTH_W-1:0] == '0) begin
                  wlast_in = '0;
               end else if (int'(csr_wdata[FRAME_WIDTH_W-1:0]) > MAX_WIDTH) begin
                  wlast_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  wlast_in = COL_W'(int'(csr_wdata[FRAME_WIDTH_W-1:0]) - 1);
               end
            end
            CSR_FRAME_HEIGHT: begin
               cfg_hit = 1'b1;
               if (csr_wdata[FRAME_HEIGHT_W-1:0] == '0) begin
                  hlast_in = '0;
               end else begin
                  hlast_in = csr_wdata[FRAME_HEIGHT_W-1:0] - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------- accept stage ----------------
   assign req_ready    = (int'(count_ff) + int'(p1_valid_ff)) < OUT_DEPTH;
   assign req_accept   = req_valid && req_ready;
   assign drain        = in_row_ff > hlast_ff;
   assign pix_emit     = (in_row_ff >= ROW_W'(2)) || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
   assign out_row_last = out_row_ff == hlast_ff;
   assign out_col_last = out_col_ff == wlast_ff;
   assign frame_last   = drain && out_row_last && out_col_last;
   assign launch       = req_accept && (drain || (req_op == OP_PIXEL));
   assign rd_addr      = drain ? out_col_ff : in_col_ff;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (cfg_hit || (req_accept && frame_last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (req_accept && (drain || req_op == OP_PIXEL)) begin
         if (!drain) begin
            if (in_col_ff == wlast_ff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 1'b1;
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
         end
         if (drain || pix_emit) begin
            if (out_col_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      p1_valid_in        = launch;
      p1_ctl_in.is_pixel = !drain;
      p1_ctl_in.emit     = drain || pix_emit;
      p1_ctl_in.interior = (out_row_ff != '0) && (out_row_ff < hlast_ff)
                           && (out_col_ff != '0) && (out_col_ff < wlast_ff);
      p1_ctl_in.last      = frame_last;
      p1_ctl_in.sel_newer = out_row_last;
      // the entry written this cycle is read stale; take the write data instead
      fwd_in = p1_valid_ff && p1_ctl_ff.is_pixel && (p1_addr_ff == rd_addr);
   end

   // ---------------- line memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem_ff[p1_addr_ff] <= wr_data;
      end
      if (launch) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   // ---------------- compute stage ----------------
   assign top     = fwd_ff ? fwd_data_ff[MEM_W-1:PIX_W] : rd_data_ff[MEM_W-1:PIX_W];
   assign mid     = fwd_ff ? fwd_data_ff[PIX_W-1:0]     : rd_data_ff[PIX_W-1:0];
   assign mem_we  = p1_valid_ff && p1_ctl_ff.is_pixel;
   assign wr_data = {mid, p1_pix_ff};

   // new column enters at the right; sum taken over the shifted window
   assign d_top   = {3'b000, top} - {3'b000, win_ff[1]};
   assign d_mid   = {3'b000, mid} - {3'b000, win_ff[4]};
   assign d_bot   = {3'b000, p1_pix_ff} - {3'b000, win_ff[7]};
   assign sum     = d_top + (d_mid << 1) + d_bot;
   assign sum_abs = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

   always_comb begin
      if (!p1_ctl_ff.is_pixel) begin
         res_pixel = p1_ctl_ff.sel_newer ? mid : top;
      end else if (p1_ctl_ff.interior) begin
         res_pixel = sum_abs[PIX_W-1:0];
      end else begin
         res_pixel = win_ff[5];
      end
   end

   always_comb begin
      win_in = win_ff;
      if (mem_we) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = top;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = mid;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = p1_pix_ff;
      end
   end

   // ---------------- result buffer ----------------
   assign push          = p1_valid_ff && p1_ctl_ff.emit;
   assign rsp_valid     = count_ff != '0;
   assign pop           = rsp_valid && rsp_ready;
   assign rsp_pixel_out = fifo_ff[rd_ptr_ff].pixel;
   assign rsp_frame_end = fifo_ff[rd_ptr_ff].frame_end;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff].pixel     <= res_pixel;
         fifo_ff[wr_ptr_ff].frame_end <= p1_ctl_ff.is_pixel ? 1'b0 : p1_ctl_ff.last;
      end
      if (launch) begin
         p1_ctl_ff   <= p1_ctl_in;
         p1_addr_ff  <= rd_addr;
         p1_pix_ff   <= req_pixel_in;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff    <= COL_W'(WLAST_RST);
         hlast_ff    <= ROW_W'(FRAME_HEIGHT_RST - 1);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         p1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         wlast_ff    <= wlast_in;
         hlast_ff    <= hlast_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         p1_valid_ff <= p1_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         win_ff      <= win_in;
      end
   end

`ifndef SYNTHESIS
   // the credit check on req_ready must keep the buffer from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (int'(count_ff) < OUT_DEPTH) || pop)
      else $error("result buffer overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= OUT_DEPTH)
      else $error("result count out of range");

   // positions stay inside the configured row
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      (in_col_ff <= wlast_ff) && (out_col_ff <= wlast_ff))
      else $error("column position beyond frame width");

   // a forwarded read must follow a pixel write stage
   a_fwd_src: assert property (@(posedge clock) disable iff (reset)
      launch && fwd_in |=> $past(mem_we))
      else $error("forwarding without a pending write");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sobel_horizontal_gradient_3x3: raster frames go in,
// and every result beat is checked against a gradient predictor kept in the bench.
// Depends on shg_pkg and the block RTL.
module tb;
   import shg_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 4;
   localparam int IDLE_PCT      = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_BEATS  = 320;
   localparam int REPORT_CAP    = 50;
   // the watchdog fails the run once the cycle count reaches this limit
   localparam int CYCLE_LIMIT   = 200_000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = '1;

   typedef struct {
      shg_op_type       op;
      logic [PIX_W-1:0] pixel;
   } beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_op = OP_PIXEL;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_frame_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sobel_horizontal_gradient_3x3 dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // gradient predictor state
   logic [PIX_W-1:0]          older_line [DEF_MAX_WIDTH];
   logic [PIX_W-1:0]          newer_line [DEF_MAX_WIDTH];
   logic [PIX_W-1:0]          win [9];
   int unsigned               col_pos, row_pos, out_pos;
   logic [FRAME_WIDTH_W-1:0]  cfg_width;
   logic [FRAME_HEIGHT_W-1:0] cfg_height;

   shg_rsp_type frame_results [$];
   beat_type    beat_queue [$];

   int unsigned beats_outstanding = 0;
   int unsigned beats_accepted = 0;
   int unsigned frame_beats = 0;
   int unsigned results_checked = 0;
   int unsigned frames_done = 0;
   int unsigned reg_writes = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          stall_enabled = 1'b1;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic int unsigned eff_width(logic [FRAME_WIDTH_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return 32'(raw);
   endfunction

   function automatic int unsigned eff_height(logic [FRAME_HEIGHT_W-1:0] raw);
      return (raw == 0) ? 1 : 32'(raw);
   endfunction

   function automatic void restart_positions();
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
   endfunction

   function automatic void check_field(string name, logic [PIX_W-1:0] want,
                                       logic [PIX_W-1:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= REPORT_CAP)
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   task automatic predict_beat(shg_op_type op, logic [PIX_W-1:0] pix);
      int unsigned      w, h, total, n, qr, qc;
      int               sum;
      logic [PIX_W-1:0] top, mid, v;
      bit               last;
      w = eff_width(cfg_width);
      h = eff_height(cfg_height);
      total = w * h;
      if (col_pos >= w || out_pos >= total) restart_positions();
      if (row_pos >= h) begin
         // whole frame is in: drain the last line plus one, all border pixels
         qr = out_pos / w;
         qc = out_pos % w;
         last = (out_pos == total - 1);
         v = (qr == h - 1) ? newer_line[qc] : older_line[qc];
         frame_results.push_back('{frame_end: last, pixel: v});
         out_pos++;
         if (last) restart_positions();
      end else if (op == OP_PIXEL) begin
         n = row_pos * w + col_pos;
         top = older_line[col_pos];
         mid = newer_line[col_pos];
         older_line[col_pos] = mid;
         newer_line[col_pos] = pix;
         for (int k = 0; k < 9; k += 3) begin
            win[k] = win[k+1];
            win[k+1] = win[k+2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = pix;
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (n >= w + 1) begin
            qr = out_pos / w;
            qc = out_pos % w;
            if (qr >= 1 && qr + 2 <= h && qc >= 1 && qc + 2 <= w) begin
               sum = (int'(win[2]) - int'(win[0]))
                   + 2 * (int'(win[5]) - int'(win[3]))
                   + (int'(win[8]) - int'(win[6]));
               if (sum < 0) sum = -sum;
               v = sum[PIX_W-1:0];
            end else begin
               v = win[4];
            end
            frame_results.push_back('{frame_end: 1'b0, pixel: v});
            out_pos++;
         end
      end
   endtask

   // result check first, then register writes and request beats of this edge
   always @(posedge clock) begin : score
      shg_rsp_type want;
      if (reset) begin
         for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            older_line[i] = '0;
            newer_line[i] = '0;
         end
         for (int i = 0; i < 9; i++) win[i] = '0;
         restart_positions();
         cfg_width = FRAME_WIDTH_W'(FRAME_WIDTH_RST);
         cfg_height = FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_results.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_CAP)
                  $error("result beat with nothing expected: pixel_out=%0d frame_end=%0b",
                         rsp_pixel_out, rsp_frame_end);
            end else begin
               want = frame_results.pop_front();
               results_checked++;
               check_field("pixel_out", want.pixel, rsp_pixel_out);
               check_field("frame_end", PIX_W'(want.frame_end), PIX_W'(rsp_frame_end));
               if (want.frame_end) frames_done++;
            end
         end
         if (csr_valid && csr_ready) begin
            reg_writes++;
            if (csr_index == CSR_FRAME_WIDTH) begin
               cfg_width = csr_wdata[FRAME_WIDTH_W-1:0];
               restart_positions();
            end else if (csr_index == CSR_FRAME_HEIGHT) begin
               cfg_height = csr_wdata[FRAME_HEIGHT_W-1:0];
               restart_positions();
            end
         end
         if (req_valid && req_ready) begin
            predict_beat(shg_op_type'(req_op), req_pixel_in);
            beats_accepted++;
            beats_outstanding--;
         end
      end
   end

   always @(posedge clock) begin : drive_req
      beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (beat_queue.size() != 0 && !(stall_enabled && $urandom_range(99) < IDLE_PCT)) begin
            beat = beat_queue.pop_front();
            req_op <= beat.op;
            req_pixel_in <= beat.pixel;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !(stall_enabled && $urandom_range(99) < IDLE_PCT);
   end

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic void queue_beat(shg_op_type op, logic [PIX_W-1:0] pix);
      beat_queue.push_back('{op: op, pixel: pix});
      beats_outstanding++;
   endfunction

   // one frame in raster order with stray flushes, then the drain steps;
   // a cut frame stops early and must be followed by a register write
   function automatic void queue_frame(int unsigned w, int unsigned h, bit cut_short);
      int unsigned npix, drain, stop;
      npix = w * h;
      drain = (npix < w + 1) ? npix : w + 1;
      stop = cut_short ? $urandom_range(npix - 1) : npix;
      for (int unsigned i = 0; i < stop; i++) begin
         if ($urandom_range(99) < 8) queue_beat(OP_FLUSH, rand_pixel());
         queue_beat(OP_PIXEL, rand_pixel());
      end
      frame_beats += stop;
      if (!cut_short) begin
         // a pixel sent during the drain is dropped and counts as a flush
         for (int unsigned i = 0; i < drain; i++)
            queue_beat(($urandom_range(99) < 15) ? OP_PIXEL : OP_FLUSH, rand_pixel());
         frame_beats += drain;
      end
   endfunction

   task automatic wait_idle();
      do @(negedge clock); while (beats_outstanding != 0 || frame_results.size() != 0);
      // a beat that makes no result may still be in the pipe
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_sized(logic [CSR_DATA_W-1:0] w_raw, logic [CSR_DATA_W-1:0] h_raw);
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, w_raw);
      write_reg(CSR_FRAME_HEIGHT, h_raw);
      @(negedge clock);
      queue_frame(eff_width(w_raw[FRAME_WIDTH_W-1:0]), eff_height(h_raw), 1'b0);
   endtask

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, frame_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int unsigned             start_beats, phase;
      logic [FRAME_WIDTH_W-1:0] w_pick;
      logic [CSR_DATA_W-1:0]   h_pick;
      bit                      cut, restart_due;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset size 640x480: nothing comes out this early, stray flush ignored
      queue_beat(OP_FLUSH, 8'h00);
      queue_beat(OP_PIXEL, 8'hFF);
      queue_beat(OP_PIXEL, 8'h00);
      wait_idle();

      // 4x3 frame: the two interior sums are +1020 and -760, both wrap
      write_reg(CSR_FRAME_WIDTH, 13'd4);
      write_reg(CSR_FRAME_HEIGHT, 13'd3);
      @(negedge clock);
      for (int r = 0; r < 3; r++) begin
         queue_beat(OP_PIXEL, 8'd0);
         queue_beat(OP_PIXEL, 8'd200);
         queue_beat(OP_PIXEL, 8'd255);
         queue_beat(OP_PIXEL, 8'd10);
         if (r == 1) queue_beat(OP_FLUSH, 8'hFF);
      end
      queue_beat(OP_FLUSH, 8'h00);
      queue_beat(OP_PIXEL, 8'h33);
      queue_beat(OP_FLUSH, 8'h00);
      queue_beat(OP_FLUSH, 8'h00);
      queue_beat(OP_FLUSH, 8'h00);
      // flush right after the frame closed: nothing pending, ignored
      queue_beat(OP_FLUSH, 8'hA5);

      // narrow and short sizes, incl. masked width bits and zero sizes
      run_sized(13'd0, 13'd7);
      run_sized(13'd1, 13'd12);
      run_sized(13'h0803, 13'd0);
      run_sized(13'h1805, 13'd4);
      run_sized(13'd2, 13'd1);

      start_beats = frame_beats;
      phase = 0;
      restart_due = 1'b0;
      w_pick = 11'd2;
      h_pick = 13'd1;
      while (frame_beats - start_beats < RANDOM_BEATS) begin
         if (restart_due || $urandom_range(99) < 40) begin
            wait_idle();
            if ($urandom_range(3) == 0) write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
            if (restart_due || $urandom_range(3) != 0) begin
               case ($urandom_range(9))
                  0: w_pick = '0;
                  1: w_pick = FRAME_WIDTH_W'($urandom_range(11, 40));
                  default: w_pick = FRAME_WIDTH_W'($urandom_range(1, 10));
               endcase
               // upper data bits are outside the width field
               write_reg(CSR_FRAME_WIDTH, {2'($urandom_range(3)), w_pick});
            end
            h_pick = ($urandom_range(9) == 0) ? '0 : CSR_DATA_W'($urandom_range(1, 6));
            write_reg(CSR_FRAME_HEIGHT, h_pick);
         end
         @(negedge clock);
         stall_enabled = !(phase >= 4 && phase < 10);
         cut = ($urandom_range(99) < 15);
         queue_frame(eff_width(w_pick), eff_height(h_pick), cut);
         restart_due = cut;
         phase++;
      end
      stall_enabled = 1'b1;
      wait_idle();

      $display("run: %0d request beats accepted, %0d result beats checked, %0d frames closed",
               beats_accepted, results_checked, frames_done);
      $display("     %0d register writes, %0d errors", reg_writes, error_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/shg_pkg.sv
rtl/sobel_horizontal_gradient_3x3.sv
tb/sv/tb.sv
